/* hw/rtl/multicolor_pixel_plot_engine_core_defines.svh */
// ----------------------------------------------------------------------------
// Multicolor pixel plot engine - assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICOLOR_PIXEL_PLOT_ENGINE_CORE_DEFINES_SVH
`define MULTICOLOR_PIXEL_PLOT_ENGINE_CORE_DEFINES_SVH

// Plain property check.
`define MPPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define MPPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mppe_pkg.sv */
// ----------------------------------------------------------------------------
// mppe_pkg
// Shared types, codes and helpers of the multicolor pixel plot engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mppe_pkg;

    localparam int CELL_COLUMNS_DEF = 40;
    localparam int CELL_ROWS_DEF    = 25;

    // Configuration register indexes
    localparam logic CFG_CAM_X = 1'b0;
    localparam logic CFG_CAM_Y = 1'b1;

    typedef enum logic [1:0] {
        OP_PLOT   = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_SETCOL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SLOT_BG = 2'd0,
        SLOT_HI = 2'd1,
        SLOT_LO = 2'd2,
        SLOT_TH = 2'd3
    } t_slot;

    typedef struct packed {
        logic load;
        logic locate;
        logic addr;
        logic read;
        logic exec;
        logic sweep;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic in_range;
        logic sweep_last;
        logic out_free;
    } t_status;

    // Bits of a bitmap byte that survive a write at pixel position pin.
    function automatic logic [7:0] keep_mask(input logic [1:0] pin);
        logic [7:0] m;
        unique case (pin)
            2'd0: m = 8'h3F;
            2'd1: m = 8'hCF;
            2'd2: m = 8'hF3;
            2'd3: m = 8'hFC;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    // Bit offset of the code of pixel position pin (leftmost in bits 7-6).
    function automatic logic [2:0] code_shift(input logic [1:0] pin);
        return {~pin, 1'b0};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mppe_ram.sv */
// ----------------------------------------------------------------------------
// mppe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mppe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/mppe_ctrl.sv */
// ----------------------------------------------------------------------------
// mppe_ctrl
// Sequencer: steps one request through locate, address, read, update and
// emit, or through the memory sweep of a clear and of the power-up fill.
// ----------------------------------------------------------------------------
`default_nettype none

module mppe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire mppe_pkg::t_status i_status,
    output mppe_pkg::t_cmd         o_cmd
);

    import mppe_pkg::*;
    `include "multicolor_pixel_plot_engine_core_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOC,
        S_ADDR,
        S_READ,
        S_EXEC,
        S_SWEEP,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_init,  n_init;
    logic   r_stall;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_init  = r_init;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_LOC;
                end
            end
            S_LOC: begin
                cmd.locate = 1'b1;
                unique case (i_status.op)
                    OP_CLEAR:  n_state = S_SWEEP;
                    OP_SETCOL: n_state = S_EMIT;
                    default:   n_state = S_ADDR;
                endcase
            end
            S_ADDR: begin
                cmd.addr = 1'b1;
                n_state  = i_status.in_range ? S_READ : S_EMIT;
            end
            S_READ: begin
                cmd.read = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                n_state  = S_EMIT;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = r_init ? S_IDLE : S_EMIT;
                    n_init  = 1'b0;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_init  <= 1'b1;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_stall;
    assign o_cmd      = cmd;

    `MPPE_ASSERT_IMPL(a_exec_after_read, r_state == S_EXEC, $past(r_state) == S_READ,
        "update step without a preceding memory read")
    `MPPE_ASSERT_IMPL(a_init_in_sweep, r_init, r_state == S_SWEEP && r_stall,
        "power-up fill left before the sweep finished")
    `MPPE_ASSERT_IMPL(a_load_when_open, cmd.load, !r_stall,
        "request taken while the input was stalled")

endmodule

`default_nettype wire

/* hw/rtl/mppe_dpath.sv */
// ----------------------------------------------------------------------------
// mppe_dpath
// Camera offset and clipping, cell addressing, slot choice, bitmap and
// attribute memories, clash counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mppe_dpath #(
    parameter int CELL_COLUMNS = mppe_pkg::CELL_COLUMNS_DEF,
    parameter int CELL_ROWS    = mppe_pkg::CELL_ROWS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mppe_pkg::t_cmd    i_cmd,
    output mppe_pkg::t_status      o_status,
    input  wire logic [1:0]        i_operation,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [4:0] i_color,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [3:0]             o_pixel_color,
    output logic [1:0]             o_slot_code,
    output logic                   o_clipped,
    output logic                   o_clash,
    output logic [15:0]            o_clash_total
);

    import mppe_pkg::*;
    `include "multicolor_pixel_plot_engine_core_defines.svh"

    localparam int CANVAS_W   = CELL_COLUMNS * 4;
    localparam int CANVAS_H   = CELL_ROWS * 8;
    localparam int CELL_COUNT = CELL_COLUMNS * CELL_ROWS;
    localparam int BYTE_COUNT = CELL_COUNT * 8;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int BYTE_AW    = CELL_AW + 3;
    localparam int COL_W      = (CELL_COLUMNS > 1) ? $clog2(CELL_COLUMNS) : 1;
    localparam int ROW_W      = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;

    // Control state
    logic signed [15:0] r_cam_x, r_cam_y;
    logic [3:0]         r_background;
    logic [3:0]         r_draw;
    logic [15:0]        r_clash_cnt;
    logic [BYTE_AW-1:0] r_sweep_cnt;
    logic               r_out_valid;

    // Request and working registers
    t_op                r_op;
    logic signed [15:0] r_x, r_y;
    logic [4:0]         r_color;
    logic [COL_W-1:0]   r_cc;
    logic [ROW_W-1:0]   r_cr;
    logic [2:0]         r_row;
    logic [1:0]         r_pin;
    logic               r_in_range;
    logic [CELL_AW-1:0] r_cell;
    logic [BYTE_AW-1:0] r_byte_addr;
    logic [3:0]         r_res_pix;
    logic [1:0]         r_res_code;
    logic               r_res_clip;
    logic               r_res_clash;
    logic [3:0]         r_out_pix;
    logic [1:0]         r_out_slot;
    logic               r_out_clipped;
    logic               r_out_clash;
    logic [15:0]        r_out_total;

    // Camera subtract and clip
    logic signed [16:0] px, py;
    logic               in_x, in_y, is_pixel_op;
    logic [CELL_AW-1:0] n_cell;

    assign px          = {r_x[15], r_x} - {r_cam_x[15], r_cam_x};
    assign py          = {r_y[15], r_y} - {r_cam_y[15], r_cam_y};
    assign in_x        = !px[16] && (px[15:0] < 16'(CANVAS_W));
    assign in_y        = !py[16] && (py[15:0] < 16'(CANVAS_H));
    assign is_pixel_op = (r_op == OP_PLOT) || (r_op == OP_READ);
    assign n_cell      = CELL_AW'(CELL_AW'(r_cr) * CELL_AW'(CELL_COLUMNS)) + CELL_AW'(r_cc);

    // Memories
    logic               bm_we, bm_re, at_we;
    logic [BYTE_AW-1:0] bm_waddr;
    logic [7:0]         bm_wdata, bm_rdata;
    logic [CELL_AW-1:0] at_waddr;
    logic [11:0]        at_wdata, at_rdata;
    logic               sweep_attr;

    // Slot choice
    logic [3:0]  k, hi, lo, th;
    logic [2:0]  shamt;
    logic [7:0]  sh_byte;
    logic [1:0]  slot_rd;
    logic [3:0]  n_pix;
    t_slot       n_slot;
    logic [11:0] n_attr;
    logic        n_clash;

    assign k       = r_color[4] ? r_draw : r_color[3:0];
    assign hi      = at_rdata[11:8];
    assign lo      = at_rdata[7:4];
    assign th      = at_rdata[3:0];
    assign shamt   = code_shift(r_pin);
    assign sh_byte = bm_rdata >> shamt;
    assign slot_rd = sh_byte[1:0];

    always_comb begin
        n_slot  = SLOT_TH;
        n_attr  = at_rdata;
        n_clash = 1'b0;
        if (k == r_background) begin
            n_slot = SLOT_BG;
        end else if (hi == k) begin
            n_slot = SLOT_HI;
        end else if (lo == k) begin
            n_slot = SLOT_LO;
        end else if (th == k) begin
            n_slot = SLOT_TH;
        end else if (hi == r_background) begin
            n_slot        = SLOT_HI;
            n_attr[11:8]  = k;
        end else if (lo == r_background) begin
            n_slot        = SLOT_LO;
            n_attr[7:4]   = k;
        end else if (th == r_background) begin
            n_slot        = SLOT_TH;
            n_attr[3:0]   = k;
        end else begin
            n_clash = 1'b1;
        end
    end

    always_comb begin
        case (slot_rd)
            2'd0:    n_pix = r_background;
            2'd1:    n_pix = hi;
            2'd2:    n_pix = lo;
            default: n_pix = th;
        endcase
    end

    // Sweep writes zero bytes everywhere and the background into every cell.
    assign sweep_attr = r_sweep_cnt < BYTE_AW'(CELL_COUNT);
    assign bm_re      = i_cmd.read;
    assign bm_we      = i_cmd.sweep || (i_cmd.exec && r_op == OP_PLOT);
    assign bm_waddr   = i_cmd.sweep ? r_sweep_cnt : r_byte_addr;
    assign bm_wdata   = i_cmd.sweep ? 8'h00
                      : ((bm_rdata & keep_mask(r_pin)) | (8'(n_slot) << shamt));
    assign at_we      = (i_cmd.sweep && sweep_attr) || (i_cmd.exec && r_op == OP_PLOT);
    assign at_waddr   = i_cmd.sweep ? r_sweep_cnt[CELL_AW-1:0] : r_cell;
    assign at_wdata   = i_cmd.sweep ? {r_background, r_background, r_background} : n_attr;

    mppe_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_COUNT),
        .AW    (BYTE_AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (r_byte_addr),
        .o_rdata (bm_rdata)
    );

    // Attribute word: pair high nibble, pair low nibble, third colour.
    mppe_ram #(
        .WIDTH (12),
        .DEPTH (CELL_COUNT),
        .AW    (CELL_AW)
    ) u_attr (
        .i_clk   (i_clk),
        .i_we    (at_we),
        .i_waddr (at_waddr),
        .i_wdata (at_wdata),
        .i_re    (bm_re),
        .i_raddr (r_cell),
        .o_rdata (at_rdata)
    );

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x      <= '0;
            r_cam_y      <= '0;
            r_background <= 4'd0;
            r_draw       <= 4'd1;
            r_clash_cnt  <= '0;
            r_sweep_cnt  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_CAM_X: r_cam_x <= i_cfg_data;
                    CFG_CAM_Y: r_cam_y <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (i_cmd.locate) begin
                if (r_op == OP_CLEAR) begin
                    r_background <= r_color[3:0];
                end
                if (r_op == OP_SETCOL) begin
                    r_draw <= r_color[3:0];
                end
            end
            if (i_cmd.exec && r_op == OP_PLOT) begin
                r_draw <= k;
                if (n_clash) begin
                    r_clash_cnt <= r_clash_cnt + 16'd1;
                end
            end
            if (i_cmd.sweep) begin
                r_sweep_cnt <= o_status.sweep_last ? '0 : r_sweep_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_operation);
            r_x     <= i_x;
            r_y     <= i_y;
            r_color <= i_color;
        end
        if (i_cmd.locate) begin
            r_cc        <= px[COL_W+1:2];
            r_cr        <= py[ROW_W+2:3];
            r_row       <= py[2:0];
            r_pin       <= px[1:0];
            r_in_range  <= in_x && in_y && is_pixel_op;
            r_res_pix   <= 4'd0;
            r_res_code  <= SLOT_BG;
            r_res_clip  <= is_pixel_op && !(in_x && in_y);
            r_res_clash <= 1'b0;
        end
        if (i_cmd.addr) begin
            r_cell      <= n_cell;
            r_byte_addr <= {n_cell, r_row};
        end
        if (i_cmd.exec) begin
            if (r_op == OP_PLOT) begin
                r_res_code  <= n_slot;
                r_res_clash <= n_clash;
            end else begin
                r_res_pix <= n_pix;
            end
        end
        if (i_cmd.emit) begin
            r_out_pix     <= r_res_pix;
            r_out_slot    <= r_res_code;
            r_out_clipped <= r_res_clip;
            r_out_clash   <= r_res_clash;
            r_out_total   <= r_clash_cnt;
        end
    end

    assign o_status.op         = r_op;
    assign o_status.in_range   = r_in_range;
    assign o_status.sweep_last = (r_sweep_cnt == BYTE_AW'(BYTE_COUNT - 1));
    assign o_status.out_free   = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_out_pix;
    assign o_slot_code   = r_out_slot;
    assign o_clipped     = r_out_clipped;
    assign o_clash       = r_out_clash;
    assign o_clash_total = r_out_total;

    `MPPE_ASSERT_IMPL(a_clash_step, !$stable(r_clash_cnt),
        $past(i_cmd.exec) && r_clash_cnt == $past(r_clash_cnt) + 16'd1,
        "clash counter moved outside a clashing plot")
    `MPPE_ASSERT_IMPL(a_valid_source, $rose(r_out_valid), $past(i_cmd.emit),
        "result presented without an emit step")
    `MPPE_ASSERT_IMPL(a_clip_quiet, r_out_valid && r_out_clipped,
        r_out_slot == SLOT_BG && r_out_pix == 4'd0 && !r_out_clash,
        "clipped result carries a colour, code or clash")

endmodule

`default_nettype wire

/* hw/rtl/multicolor_pixel_plot_engine_core.sv */
// ----------------------------------------------------------------------------
// Multicolor pixel plot engine core
// Two-bit-per-pixel cell-attribute bitmap with plot, read, clear and set-colour.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall) takes one request: operation,
//    x, y, color. Output channel (o_out_valid / i_out_stall) returns exactly
//    one result per request, in order.
//  - Camera offsets cam_x (index 0) and cam_y (index 1) are written through
//    i_cfg_wr_en / i_cfg_index / i_cfg_data while the engine is idle.
//  - Plot and read: the sequencer handles one request at a time: locate,
//    address, memory read, update. A clipped request skips the memory steps.
//  - Set colour: goes from locate straight to the result.
//  - Clear: sweeps every bitmap byte, one per cycle, refilling the cell
//    attributes on the way, then returns its result.
//  - Reset: the same sweep runs with background 0; o_in_stall stays high
//    until it ends.
//  - A stalled receiver holds the result in the output register; the engine
//    takes the next request meanwhile and waits with the following result.
// ----------------------------------------------------------------------------
`default_nettype none

module multicolor_pixel_plot_engine_core #(
    parameter int CELL_COLUMNS = mppe_pkg::CELL_COLUMNS_DEF,
    parameter int CELL_ROWS    = mppe_pkg::CELL_ROWS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [4:0]  i_color,
    // Camera registers
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    // Result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [3:0]              o_pixel_color,
    output logic [1:0]              o_slot_code,
    output logic                    o_clipped,
    output logic                    o_clash,
    output logic [15:0]             o_clash_total
);

    import mppe_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence each request; hold the input stalled while one is in flight.
    mppe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold the canvas, cell attributes, colours, counter and result register.
    mppe_dpath #(
        .CELL_COLUMNS (CELL_COLUMNS),
        .CELL_ROWS    (CELL_ROWS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_operation),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_color       (i_color),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_slot_code   (o_slot_code),
        .o_clipped     (o_clipped),
        .o_clash       (o_clash),
        .o_clash_total (o_clash_total)
    );

endmodule

`default_nettype wire

/* dv/multicolor_pixel_plot_engine_core_tb.sv */
// ----------------------------------------------------------------------------
// Multicolor pixel plot engine core - testbench
// Sends plot, read, clear and set-colour requests under several camera
// offsets, with random gaps on both channels, and checks every result field
// against a canvas model kept inside the bench, or a directed row's typed result.
// ----------------------------------------------------------------------------
module multicolor_pixel_plot_engine_core_tb;
    import mppe_pkg::*;

    localparam int COLS        = CELL_COLUMNS_DEF;
    localparam int ROWS        = CELL_ROWS_DEF;
    localparam int CANVAS_W    = COLS * 4;
    localparam int CANVAS_H    = ROWS * 8;
    localparam int CELLS       = COLS * ROWS;
    localparam int BYTES       = CELLS * 8;
    // A clear or the reset sweep leaves both channels still while it runs.
    localparam int QUIET_LIMIT = 40000;
    localparam int LONG_HOLD   = 300;
    localparam int PER_CAMERA  = 176;
    localparam int CLASH_RUNS  = 40;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 32;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [4:0]  color;
    } t_pixel_req;

    typedef struct packed {
        logic [3:0]  pixel_color;
        t_slot       slot_code;
        logic        clipped;
        logic        clash;
        logic [15:0] clash_total;
    } t_pixel_res;

    typedef struct packed {
        t_pixel_req req;
        logic       typed;
        t_pixel_res res;
    } t_table_row;

    localparam t_pixel_res IDLE_RES = '{4'd0, SLOT_BG, 1'b0, 1'b0, 16'd0};
    localparam t_pixel_res CLIP_RES = '{4'd0, SLOT_BG, 1'b1, 1'b0, 16'd0};

    // Directed requests; typed rows carry their result, the rest use the model.
    t_table_row dir_rows [24] = '{
        '{'{OP_READ,   16'sd0,     16'sd0,     5'sd0  }, 1'b1, IDLE_RES},
        '{'{OP_READ,   16'sd159,   16'sd199,   5'sd15 }, 1'b1, IDLE_RES},
        '{'{OP_READ,   -16'sd1,    16'sd0,     5'sd0  }, 1'b1, CLIP_RES},
        '{'{OP_READ,   16'sd160,   16'sd5,     5'sd0  }, 1'b1, CLIP_RES},
        '{'{OP_READ,   16'sd3,     16'sd200,   5'sd0  }, 1'b1, CLIP_RES},
        '{'{OP_PLOT,   16'sh7FFF,  16'sh8000,  5'sd5  }, 1'b1, CLIP_RES},
        '{'{OP_PLOT,   16'sd0,     16'sd0,     -5'sd1 }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd1,     16'sd0,     5'sd0  }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd2,     16'sd0,     5'sd2  }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd3,     16'sd0,     5'sd3  }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd0,     16'sd7,     5'sd9  }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd1,     16'sd7,     5'sd1  }, 1'b0, IDLE_RES},
        '{'{OP_READ,   16'sd0,     16'sd7,     5'sd0  }, 1'b0, IDLE_RES},
        '{'{OP_READ,   16'sd3,     16'sd0,     5'sd0  }, 1'b0, IDLE_RES},
        '{'{OP_READ,   16'sd1,     16'sd0,     5'sd0  }, 1'b0, IDLE_RES},
        '{'{OP_SETCOL, 16'sd0,     16'sd0,     -5'sd1 }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd159,   16'sd199,   -5'sd1 }, 1'b0, IDLE_RES},
        '{'{OP_READ,   16'sd159,   16'sd199,   5'sd0  }, 1'b0, IDLE_RES},
        '{'{OP_CLEAR,  16'sh8000,  16'sh7FFF,  -5'sd1 }, 1'b0, IDLE_RES},
        '{'{OP_READ,   16'sd0,     16'sd0,     5'sd0  }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd4,     16'sd8,     5'sd15 }, 1'b0, IDLE_RES},
        '{'{OP_PLOT,   16'sd4,     16'sd8,     5'sh10 }, 1'b0, IDLE_RES},
        '{'{OP_CLEAR,  16'sd0,     16'sd0,     5'sd0  }, 1'b0, IDLE_RES},
        '{'{OP_SETCOL, 16'sd0,     16'sd0,     5'sd7  }, 1'b0, IDLE_RES}
    };

    // Camera settings of the random phases; the last one is drawn at run time.
    int cam_plan_x [5] = '{-100, 32767, -32768, 37, 0};
    int cam_plan_y [5] = '{50, -32768, 32767, -15, 0};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_op                operation = OP_PLOT;
    logic signed [15:0] x         = '0;
    logic signed [15:0] y         = '0;
    logic signed [4:0]  color     = '0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = CFG_CAM_X;
    logic [15:0]        cfg_data  = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [3:0]         pixel_color;
    logic [1:0]         slot_code;
    logic               clipped;
    logic               clash;
    logic [15:0]        clash_total;

    // Shared knobs between the request and result sides.
    logic no_idle       = 1'b0;
    logic long_hold_req = 1'b0;

    // Canvas model state.
    logic [7:0]  bitmap_q [BYTES];
    logic [7:0]  pairs_q  [CELLS];
    logic [3:0]  third_q  [CELLS];
    logic [3:0]  bg_q;
    logic [3:0]  draw_q;
    logic [15:0] clashes_q;
    int          cam_x_q;
    int          cam_y_q;

    t_pixel_res canvas_results_q [$];
    int         mismatches   = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;

    multicolor_pixel_plot_engine_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_x           (x),
        .i_y           (y),
        .i_color       (color),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_color (pixel_color),
        .o_slot_code   (slot_code),
        .o_clipped     (clipped),
        .o_clash       (clash),
        .o_clash_total (clash_total)
    );

    always #2 clk = ~clk;

    // Subtract the camera and clip; give byte address, cell and column in cell.
    function automatic bit find_pixel(input logic signed [15:0] xin,
                                      input logic signed [15:0] yin,
                                      output int byte_at, output int cell_at,
                                      output int pin);
        int px;
        int py;
        px = int'(xin) - cam_x_q;
        py = int'(yin) - cam_y_q;
        if (px < 0 || px >= CANVAS_W || py < 0 || py >= CANVAS_H) return 1'b0;
        pin     = px % 4;
        cell_at = (py / 8) * COLS + px / 4;
        byte_at = (py / 8) * COLS * 8 + (px / 4) * 8 + py % 8;
        return 1'b1;
    endfunction

    task automatic refill_canvas(input logic [3:0] fill);
        bg_q = fill;
        foreach (bitmap_q[i]) bitmap_q[i] = 8'd0;
        foreach (pairs_q[i]) pairs_q[i] = {fill, fill};
        foreach (third_q[i]) third_q[i] = fill;
    endtask

    // Apply one request to the canvas model and give the result it owes.
    task automatic run_canvas_op(input t_pixel_req r, output t_pixel_res res);
        int         byte_at;
        int         cell_at;
        int         pin;
        int         shift;
        logic [3:0] k;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [3:0] th;
        t_slot      slot;
        res = IDLE_RES;
        case (r.op)
            OP_PLOT: begin
                if (!find_pixel(r.x, r.y, byte_at, cell_at, pin)) begin
                    // A clipped plot leaves even the drawing colour alone.
                    res.clipped = 1'b1;
                end else begin
                    if (!r.color[4]) draw_q = r.color[3:0];
                    k  = draw_q;
                    hi = pairs_q[cell_at][7:4];
                    lo = pairs_q[cell_at][3:0];
                    th = third_q[cell_at];
                    if (k == bg_q) begin
                        slot = SLOT_BG;
                    end else if (hi == k) begin
                        slot = SLOT_HI;
                    end else if (lo == k) begin
                        slot = SLOT_LO;
                    end else if (th == k) begin
                        slot = SLOT_TH;
                    end else if (hi == bg_q) begin
                        pairs_q[cell_at][7:4] = k;
                        slot = SLOT_HI;
                    end else if (lo == bg_q) begin
                        pairs_q[cell_at][3:0] = k;
                        slot = SLOT_LO;
                    end else if (th == bg_q) begin
                        third_q[cell_at] = k;
                        slot = SLOT_TH;
                    end else begin
                        // Cell is full of other colors: count it, reuse the third slot.
                        clashes_q = clashes_q + 16'd1;
                        res.clash = 1'b1;
                        slot = SLOT_TH;
                    end
                    shift = 6 - 2 * pin;
                    bitmap_q[byte_at][shift +: 2] = slot;
                    res.slot_code = slot;
                end
            end
            OP_READ: begin
                if (!find_pixel(r.x, r.y, byte_at, cell_at, pin)) begin
                    res.clipped = 1'b1;
                end else begin
                    shift = 6 - 2 * pin;
                    slot  = t_slot'(bitmap_q[byte_at][shift +: 2]);
                    case (slot)
                        SLOT_BG: res.pixel_color = bg_q;
                        SLOT_HI: res.pixel_color = pairs_q[cell_at][7:4];
                        SLOT_LO: res.pixel_color = pairs_q[cell_at][3:0];
                        default: res.pixel_color = third_q[cell_at];
                    endcase
                end
            end
            OP_CLEAR: refill_canvas(r.color[3:0]);
            default:  draw_q = r.color[3:0];
        endcase
        res.clash_total = clashes_q;
    endtask

    task automatic flag_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("result %0d: %s is %0d, should be %0d", results_seen, field, got, want);
    endtask

    // Hold the request until taken, then log what the canvas owes for it.
    task automatic offer_request(input t_pixel_req r, input logic typed,
                                 input t_pixel_res typed_res);
        int         gap;
        t_pixel_res res;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation <= r.op;
        x         <= r.x;
        y         <= r.y;
        color     <= r.color;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        run_canvas_op(r, res);
        canvas_results_q.push_back(typed ? typed_res : res);
    endtask

    // Drop valid and wait until every owed result is back and the engine settles.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (canvas_results_q.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_camera(input int cx, input int cy);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CAM_X;
        cfg_data  <= 16'(cx);
        @(negedge clk);
        cfg_index <= CFG_CAM_Y;
        cfg_data  <= 16'(cy);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cam_x_q = cx;
        cam_y_q = cy;
    endtask

    task automatic make_random_request(output t_pixel_req r);
        int sel;
        int spot;
        int px;
        int py;
        sel  = $urandom_range(0, 199);
        spot = $urandom_range(0, 9);
        if (sel < 110)      r.op = OP_PLOT;
        else if (sel < 172) r.op = OP_READ;
        else if (sel < 196) r.op = OP_SETCOL;
        else                r.op = OP_CLEAR;
        if (spot < 4) begin
            // Crowd a few corner cells so slots fill up and clash.
            px = $urandom_range(0, 7);
            py = $urandom_range(0, 15);
        end else if (spot < 8) begin
            px = $urandom_range(0, CANVAS_W - 1);
            py = $urandom_range(0, CANVAS_H - 1);
        end else begin
            px = int'($urandom_range(0, CANVAS_W + 7)) - 4;
            py = int'($urandom_range(0, CANVAS_H + 7)) - 4;
        end
        r.x = 16'(cam_x_q + px);
        r.y = 16'(cam_y_q + py);
        if (spot == 9) begin
            r.x = 16'($urandom);
            r.y = 16'($urandom);
        end
        if ($urandom_range(0, 6) == 0) r.color = 5'($urandom);
        else                           r.color = 5'($urandom_range(0, 15));
    endtask

    // Result side: stall a random count per result, or a long stretch on request.
    initial begin : result_sink
        int hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 11);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
        end
    end

    // Compare each taken result with the oldest owed one.
    always @(posedge clk) begin : check_results
        t_pixel_res want;
        if (out_valid === 1'b1 && !out_stall) begin
            if (canvas_results_q.size() == 0) begin
                flag_mismatch("unrequested result", 1, 0);
            end else begin
                want = canvas_results_q.pop_front();
                if (pixel_color !== want.pixel_color)
                    flag_mismatch("pixel_color", pixel_color, want.pixel_color);
                if (slot_code !== want.slot_code)
                    flag_mismatch("slot_code", slot_code, want.slot_code);
                if (clipped !== want.clipped)
                    flag_mismatch("clipped", clipped, want.clipped);
                if (clash !== want.clash)
                    flag_mismatch("clash", clash, want.clash);
                if (clash_total !== want.clash_total)
                    flag_mismatch("clash_total", clash_total, want.clash_total);
            end
            results_seen++;
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_pixel_req req;
        refill_canvas(4'd0);
        draw_q    = 4'd1;
        clashes_q = 16'd0;
        cam_x_q   = 0;
        cam_y_q   = 0;
        cam_plan_x[4] = int'($signed(16'($urandom)));
        cam_plan_y[4] = int'($signed(16'($urandom)));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        // Fill one cell with three colors, then hammer a fourth so the
        // clash counter keeps climbing.
        no_idle = 1'b1;
        offer_request('{OP_PLOT, 16'sd8, 16'sd16, 5'sd1}, 1'b0, IDLE_RES);
        offer_request('{OP_PLOT, 16'sd9, 16'sd16, 5'sd2}, 1'b0, IDLE_RES);
        offer_request('{OP_PLOT, 16'sd10, 16'sd16, 5'sd3}, 1'b0, IDLE_RES);
        repeat (CLASH_RUNS) offer_request('{OP_PLOT, 16'sd11, 16'sd17, 5'sd4}, 1'b0, IDLE_RES);
        offer_request('{OP_READ, 16'sd11, 16'sd17, 5'sd0}, 1'b0, IDLE_RES);
        no_idle = 1'b0;

        for (int p = 0; p < 5; p++) begin
            drain_results();
            set_camera(cam_plan_x[p], cam_plan_y[p]);
            for (int n = 0; n < PER_CAMERA; n++) begin
                if (n % 48 == 0) no_idle = ($urandom_range(0, 3) == 0);
                // Park the result side so the engine backs up into the request side.
                if (p == 1 && n == 60) long_hold_req = 1'b1;
                // Pause requests until everything owed has come back.
                if (p == 2 && n == 100) drain_results();
                make_random_request(req);
                offer_request(req, 1'b0, IDLE_RES);
            end
        end

        drain_results();
        repeat (TAIL) @(negedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
